// ===== hw/rtl/redb_pkg.sv =====
// Package for the rotary encoder detent and button block.
// Holds register indexes, reset values and the quadrature step decode.
// No dependencies.
package redb_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_TRANSITIONS_PER_DETENT = 2'd0;
	localparam logic [1:0] REG_BUTTON_ENABLE          = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE_MS            = 2'd2;

	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 2;

	// Reset values of the configuration registers
	localparam logic [3:0] TPD_RESET      = 4'd4;
	localparam logic       BTN_EN_RESET   = 1'b1;
	localparam logic [7:0] DEBOUNCE_RESET = 8'd30;

	// Step codes
	localparam logic signed [1:0] STEP_NONE = 2'sd0;
	localparam logic signed [1:0] STEP_UP   = 2'sd1;
	localparam logic signed [1:0] STEP_DOWN = -2'sd1;

	// Quadrature step, indexed by {previous AB, current AB}
	function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
		logic signed [1:0] s;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: s = STEP_DOWN;
			4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
			default: s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/rotary_encoder_detent_and_button.sv =====
// Top level of the rotary encoder detent and button block.
// Input register, one pass of decode/debounce logic, result register.
// Depends on redb_pkg.

// One result per sample. A sample is taken into an input register. The
// quadrature decode, detent accumulate and button debounce then run
// combinationally between that register and the result register. A sample
// can be accepted every clock unless in_stall is high. A held result stalls
// the input only once the input register is also full. The encoder and
// button state is updated in that single stage, which keeps back to back
// samples in order. The first sample after reset only loads the AB pair.
// Configuration must be written while no sample is in flight.
module rotary_encoder_detent_and_button
	import redb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// sample channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    enc_a,
	input  logic                    enc_b,
	input  logic                    button_level,
	input  logic [31:0]             now_ms,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [1:0]       detent_step,
	output logic signed [15:0]      detent_total,
	output logic                    click,
	output logic                    button_stable
);

	// configuration registers
	logic [3:0] tpd_q;
	logic       btn_en_q;
	logic [7:0] debounce_q;

	// input stage
	logic        valid_s1;
	logic        a_s1, b_s1, btn_s1;
	logic [31:0] now_s1;

	// block state
	logic              primed_q;
	logic [1:0]        prev_ab_q;
	logic signed [4:0] acc_q;
	logic [15:0]       detent_count_q;
	logic              raw_last_q;
	logic [31:0]       last_change_q;
	logic              accepted_q;
	logic              press_latch_q;

	// result register
	logic out_valid_q;

	logic advance;
	logic fire;

	// next-state values
	logic              primed_n;
	logic [1:0]        prev_ab_n;
	logic signed [4:0] acc_n;
	logic [15:0]       detent_count_n;
	logic              raw_last_n;
	logic [31:0]       last_change_n;
	logic              accepted_n;
	logic              press_latch_n;
	logic signed [1:0] step_n;
	logic              click_n;

	logic [1:0]        ab;
	logic signed [1:0] qstep;
	logic [3:0]        tpd_eff;
	logic signed [5:0] tpd6;
	logic signed [5:0] sum6;
	logic [31:0]       elapsed;

	// handshake: the result register frees up when empty or taken
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign fire      = valid_s1 && advance;
	assign out_valid = out_valid_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpd_q      <= TPD_RESET;
			btn_en_q   <= BTN_EN_RESET;
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRANSITIONS_PER_DETENT: tpd_q <= cfg_data[3:0];
				REG_BUTTON_ENABLE:          btn_en_q <= cfg_data[0];
				REG_DEBOUNCE_MS:            debounce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			a_s1   <= enc_a;
			b_s1   <= enc_b;
			btn_s1 <= button_level;
			now_s1 <= now_ms;
		end
	end

	// decode, detent accumulate and debounce for the sample in stage 1
	always_comb begin
		ab      = {a_s1, b_s1};
		qstep   = quad_step({prev_ab_q, ab});
		tpd_eff = (tpd_q == 4'd0) ? 4'd1 : tpd_q;
		tpd6    = signed'({2'b00, tpd_eff});
		sum6    = 6'(acc_q) + 6'(qstep);

		primed_n       = 1'b1;
		prev_ab_n      = prev_ab_q;
		acc_n          = acc_q;
		detent_count_n = detent_count_q;
		raw_last_n     = raw_last_q;
		last_change_n  = last_change_q;
		accepted_n     = accepted_q;
		press_latch_n  = press_latch_q;
		step_n         = STEP_NONE;
		click_n        = 1'b0;
		elapsed        = 32'd0;

		if (!primed_q) begin
			prev_ab_n = ab;
		end else begin
			// encoder
			if (ab != prev_ab_q) begin
				prev_ab_n = ab;
				if (sum6 >= tpd6) begin
					acc_n          = 5'(sum6 - tpd6);
					detent_count_n = detent_count_q + 16'd1;
					step_n         = STEP_UP;
				end else if (sum6 <= -tpd6) begin
					acc_n          = 5'(sum6 + tpd6);
					detent_count_n = detent_count_q - 16'd1;
					step_n         = STEP_DOWN;
				end else begin
					acc_n = 5'(sum6);
				end
			end
			// button debounce, wrapping time difference
			if (btn_en_q) begin
				if (btn_s1 != raw_last_q) begin
					raw_last_n    = btn_s1;
					last_change_n = now_s1;
				end
				elapsed = now_s1 - last_change_n;
				if (elapsed >= {24'd0, debounce_q} && raw_last_n != accepted_q) begin
					accepted_n = raw_last_n;
					if (!raw_last_n) begin
						press_latch_n = 1'b1;
					end else if (press_latch_q) begin
						press_latch_n = 1'b0;
						click_n       = 1'b1;
					end
				end
			end
		end
	end

	// state update, one sample per transfer out of stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q       <= 1'b0;
			prev_ab_q      <= 2'b00;
			acc_q          <= 5'sd0;
			detent_count_q <= 16'd0;
			raw_last_q     <= 1'b1;
			last_change_q  <= 32'd0;
			accepted_q     <= 1'b1;
			press_latch_q  <= 1'b0;
		end else if (fire) begin
			primed_q       <= primed_n;
			prev_ab_q      <= prev_ab_n;
			acc_q          <= acc_n;
			detent_count_q <= detent_count_n;
			raw_last_q     <= raw_last_n;
			last_change_q  <= last_change_n;
			accepted_q     <= accepted_n;
			press_latch_q  <= press_latch_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			detent_step   <= step_n;
			detent_total  <= signed'(detent_count_n);
			click         <= click_n;
			button_stable <= accepted_n;
		end
	end

`ifndef NO_ASSERTIONS
	// a pending press always sits on a pressed debounced level
	a_latch_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		press_latch_q |-> !accepted_q)
		else $error("press latch set while button released");

	// a click is only reported together with a released level
	a_click_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && click) |-> button_stable)
		else $error("click without released level");

	// the step code never takes the unused value
	a_step_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (detent_step != 2'b10))
		else $error("illegal detent step code");

	// the transition count keeps clear of the most negative code
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q != -5'sd16)
		else $error("transition count out of range");
`endif

endmodule

// ===== bench/redb_result_checker.sv =====
// Result checker for the rotary encoder detent and button block.
// Watches the config port and both channels, predicts each result, compares.
// Depends on redb_pkg.
module redb_result_checker
	import redb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  enc_a,
	input  logic                  enc_b,
	input  logic                  button_level,
	input  logic [31:0]           now_ms,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic signed [1:0]     detent_step,
	input  logic signed [15:0]    detent_total,
	input  logic                  click,
	input  logic                  button_stable,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [1:0]  step;
		logic signed [15:0] total;
		logic               clicked;
		logic               stable;
	} encoder_result_t;

	// Quadrature step indexed by {previous AB, current AB}
	localparam logic signed [1:0] QUAD_LUT [16] = '{
		STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
		STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
		STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
		STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
	};

	// Shadow configuration
	logic [3:0]        tpd_cfg;
	logic              btn_en;
	logic [7:0]        deb_cfg;

	// Shadow encoder and button state
	logic              primed;
	logic [1:0]        last_ab;
	logic signed [4:0] acc;
	logic [15:0]       detents;
	logic              raw_prev;
	logic [31:0]       changed_at;
	logic              level;
	logic              press_held;

	encoder_result_t   expected_q [$];
	int unsigned       fail_count;

	assign mismatches = fail_count;

	// Advances the shadow state by one sample and returns the result it gives
	function automatic encoder_result_t decode_sample(input logic a, input logic b,
			input logic btn, input logic [31:0] ms);
		logic [1:0]        ab;
		logic signed [5:0] tpd;
		logic [31:0]       quiet;
		encoder_result_t   r;
		ab = {a, b};
		r.step = STEP_NONE;
		r.clicked = 1'b0;
		if (!primed) begin
			// first sample only loads the AB pair
			primed = 1'b1;
			last_ab = ab;
		end else begin
			if (ab != last_ab) begin
				tpd = (tpd_cfg == 4'd0) ? 6'sd1 : $signed({2'b00, tpd_cfg});
				acc = acc + QUAD_LUT[{last_ab, ab}];
				last_ab = ab;
				if (acc >= tpd) begin
					acc = 5'(acc - tpd);
					detents = detents + 16'd1;
					r.step = STEP_UP;
				end else if (acc <= -tpd) begin
					acc = 5'(acc + tpd);
					detents = detents - 16'd1;
					r.step = STEP_DOWN;
				end
			end
			if (btn_en) begin
				if (btn != raw_prev) begin
					raw_prev = btn;
					changed_at = ms;
				end
				// wrapping elapsed time since last raw edge
				quiet = ms - changed_at;
				if (quiet >= {24'd0, deb_cfg} && raw_prev != level) begin
					level = raw_prev;
					if (!level)
						press_held = 1'b1;
					else if (press_held) begin
						press_held = 1'b0;
						r.clicked = 1'b1;
					end
				end
			end
		end
		r.total = detents;
		r.stable = level;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		encoder_result_t want;
		if (!arst_n) begin
			tpd_cfg = TPD_RESET;
			btn_en = BTN_EN_RESET;
			deb_cfg = DEBOUNCE_RESET;
			primed = 1'b0;
			last_ab = 2'd0;
			acc = '0;
			detents = '0;
			raw_prev = 1'b1;
			changed_at = '0;
			level = 1'b1;
			press_held = 1'b0;
			expected_q.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			// result transfer: compare against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with nothing expected: step %0d total %0d click %0b stable %0b",
						$time, detent_step, detent_total, click, button_stable);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (detent_step !== want.step) begin
						$display("%0t: detent_step expected %0d got %0d", $time, want.step,
							detent_step);
						fail_count++;
					end
					if (detent_total !== want.total) begin
						$display("%0t: detent_total expected %0d got %0d", $time, want.total,
							detent_total);
						fail_count++;
					end
					if (click !== want.clicked) begin
						$display("%0t: click expected %0b got %0b", $time, want.clicked, click);
						fail_count++;
					end
					if (button_stable !== want.stable) begin
						$display("%0t: button_stable expected %0b got %0b", $time, want.stable,
							button_stable);
						fail_count++;
					end
				end
			end
			// sample transfer: predict its result
			if (in_valid && !in_stall)
				expected_q.push_back(decode_sample(enc_a, enc_b, button_level, now_ms));
			// register writes must only land while idle; the checker does not enforce it
			if (cfg_we) begin
				case (cfg_index)
					REG_TRANSITIONS_PER_DETENT: tpd_cfg = cfg_data[3:0];
					REG_BUTTON_ENABLE:          btn_en = cfg_data[0];
					REG_DEBOUNCE_MS:            deb_cfg = cfg_data[7:0];
					default: ;
				endcase
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== bench/rotary_encoder_detent_and_button_tb.sv =====
// Testbench top for the rotary encoder detent and button block.
// Drives samples and register writes, varies idling, reports the verdict.
// Depends on redb_pkg, rotary_encoder_detent_and_button and redb_result_checker.
module rotary_encoder_detent_and_button_tb;
	import redb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT   = 100000;
	localparam int          ITEMS_PER_SET = 147;
	localparam int          SET_COUNT     = 6;
	// unused register slot, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Gray order of AB in the up direction
	localparam logic [1:0] GRAY_FWD [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

	// Register settings per random set
	localparam logic [3:0] TPD_SET [SET_COUNT] = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd2, 4'd4};
	localparam logic       BTN_SET [SET_COUNT] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
	localparam logic [7:0] DEB_SET [SET_COUNT] = '{8'd0, 8'd255, 8'd7, 8'd30, 8'd1, 8'd20};

	typedef enum logic [1:0] {MOVE_HOLD, MOVE_FWD, MOVE_BACK, MOVE_JUMP} move_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  enc_a = 1'b0;
	logic                  enc_b = 1'b0;
	logic                  button_level = 1'b1;
	logic [31:0]           now_ms = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [1:0]     detent_step;
	logic signed [15:0]    detent_total;
	logic                  click;
	logic                  button_stable;
	int unsigned           mismatches;
	int unsigned           outstanding;

	int unsigned           tx_idle_pct = 18;
	int unsigned           rx_idle_pct = 55;
	int unsigned           cycles = 0;
	logic [1:0]            pos = 2'd0;
	logic [7:0]            deb_now = DEBOUNCE_RESET;

	rotary_encoder_detent_and_button u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.enc_a         (enc_a),
		.enc_b         (enc_b),
		.button_level  (button_level),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.detent_step   (detent_step),
		.detent_total  (detent_total),
		.click         (click),
		.button_stable (button_stable)
	);

	redb_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.enc_a         (enc_a),
		.enc_b         (enc_b),
		.button_level  (button_level),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.detent_step   (detent_step),
		.detent_total  (detent_total),
		.click         (click),
		.button_stable (button_stable),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// One sample transfer; the encoder moves along the Gray order
	task automatic send_move(input move_e mv, input logic btn, input logic [31:0] ms);
		logic [1:0] ab;
		case (mv)
			MOVE_FWD:  pos = pos + 2'd1;
			MOVE_BACK: pos = pos - 2'd1;
			MOVE_JUMP: pos = pos + 2'd2;
			default: ;
		endcase
		ab = GRAY_FWD[pos];
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		enc_a <= ab[1];
		enc_b <= ab[0];
		button_level <= btn;
		now_ms <= ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Stop sending and wait until every result has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned r;
		move_e       mv;
		logic        fwd_run;
		int          run_left;
		logic        btn_q;
		int          hold_left;
		logic [31:0] ms_q;

		fwd_run = 1'b1;
		run_left = 0;
		btn_q = 1'b1;
		hold_left = 0;
		ms_q = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: priming, detent up across the time wrap, click, bounce
		send_move(MOVE_HOLD, 1'b0, 32'hFFFF_FFF0);
		send_move(MOVE_FWD,  1'b0, 32'hFFFF_FFF5);
		send_move(MOVE_FWD,  1'b0, 32'hFFFF_FFFF);
		send_move(MOVE_FWD,  1'b0, 32'h0000_0005);
		send_move(MOVE_FWD,  1'b0, 32'h0000_0013);
		send_move(MOVE_HOLD, 1'b1, 32'h0000_0014);
		send_move(MOVE_JUMP, 1'b1, 32'h0000_0020);
		send_move(MOVE_BACK, 1'b1, 32'h0000_0028);
		send_move(MOVE_BACK, 1'b1, 32'h0000_0030);
		send_move(MOVE_BACK, 1'b1, 32'h0000_0031);
		send_move(MOVE_BACK, 1'b1, 32'h0000_0032);
		send_move(MOVE_FWD,  1'b0, 32'h0000_0040);
		send_move(MOVE_HOLD, 1'b1, 32'h0000_0041);
		send_move(MOVE_BACK, 1'b1, 32'h0000_0080);
		send_move(MOVE_FWD,  1'b0, 32'hFFFF_FFFF);
		send_move(MOVE_JUMP, 1'b0, 32'h0000_0000);
		send_move(MOVE_FWD,  1'b0, 32'h7FFF_FFFF);
		send_move(MOVE_FWD,  1'b1, 32'h8000_0000);
		send_move(MOVE_FWD,  1'b1, 32'h8000_0020);
		ms_q = 32'h8000_0020;

		// Random sets, each under its own register setting
		for (int p = 0; p < SET_COUNT; p++) begin
			settle();
			tx_idle_pct = (p < 2) ? 18 : (p < 4) ? 55 : 0;
			rx_idle_pct = (p < 2) ? 55 : (p < 4) ? 18 : 0;
			write_reg(REG_TRANSITIONS_PER_DETENT, {4'd0, TPD_SET[p]});
			write_reg(REG_BUTTON_ENABLE, {7'd0, BTN_SET[p]});
			write_reg(REG_DEBOUNCE_MS, DEB_SET[p]);
			if (p == 3)
				write_reg(REG_UNUSED, 8'hFF);
			deb_now = DEB_SET[p];
			if (p == 1)
				ms_q = 32'hFFFF_FF80;

			for (int n = 0; n < ITEMS_PER_SET; n++) begin
				// encoder: mostly clean runs, some jitter and illegal jumps
				if (run_left == 0) begin
					fwd_run = 1'($urandom_range(0, 1));
					run_left = $urandom_range(1, 20);
				end
				run_left--;
				r = $urandom_range(0, 99);
				if (r < 70)
					mv = fwd_run ? MOVE_FWD : MOVE_BACK;
				else if (r < 85)
					mv = MOVE_HOLD;
				else if (r < 93)
					mv = fwd_run ? MOVE_BACK : MOVE_FWD;
				else
					mv = MOVE_JUMP;

				// button: held levels with occasional single-sample bounce
				if (hold_left == 0) begin
					btn_q = ~btn_q;
					hold_left = ($urandom_range(0, 99) < 15) ? 1 : $urandom_range(1, 15);
				end
				hold_left--;

				// time: small advances, debounce-sized gaps, jumps, steps back
				r = $urandom_range(0, 99);
				if (r < 88)
					ms_q += $urandom_range(0, deb_now / 3 + 4);
				else if (r < 94)
					ms_q += $urandom_range(deb_now, deb_now + 50);
				else if (r < 97)
					ms_q = $urandom;
				else
					ms_q -= $urandom_range(1, 100);

				// hold off until the block has drained
				if (n == 60 || $urandom_range(0, 99) == 0)
					settle();
				send_move(mv, btn_q, ms_q);
			end
		end

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
